[rtl/midpoint_ellipse_rasterizer_assert.svh]
// Assertion macros for the midpoint ellipse rasterizer.
// Needs a signal named clock and a signal named reset in the including module.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset
`define MER_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Next-cycle implication, checked at every rising clock edge out of reset
`define MER_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define MER_ASSERT_NOW(label, ante, cons)
`define MER_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/mer_pkg.sv]
// Shared widths, codes and types of the midpoint ellipse rasterizer.
// No dependencies; every other source file but the assertion header imports it.
package mer_pkg;

   // coordinate width of the centre and semi-axis fields
   localparam int COORD_BITS = 10;
   // width of the wrapped output coordinates
   localparam int OUT_BITS   = 12;
   // widths derived from the coordinate width
   localparam int SQ_W    = 2 * COORD_BITS;
   localparam int OFFX_W  = COORD_BITS + 1;
   localparam int OFFY_W  = COORD_BITS + 2;
   localparam int SLOPE_W = 3 * COORD_BITS + 4;
   localparam int DEC_W   = 4 * COORD_BITS + 8;
   localparam int MUL_W   = 2 * COORD_BITS + 6;
   localparam int PROD_W  = 2 * MUL_W;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } command_type;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [OUT_BITS-1:0] pix_type;
   typedef logic signed [MUL_W-1:0]    mul_op_type;
   typedef logic signed [PROD_W-1:0]   mul_prod_type;

endpackage

[rtl/mer_req_if.sv]
// Request channel of the midpoint ellipse rasterizer: valid/ready plus command word.
// Depends on mer_pkg.
interface mer_req_if;
   import mer_pkg::*;

   logic        valid;
   logic        ready;
   command_type command;
   coord_type   center_x;
   coord_type   center_y;
   coord_type   semi_axis_x;
   coord_type   semi_axis_y;

   modport source (
      output valid, command, center_x, center_y, semi_axis_x, semi_axis_y,
      input  ready
   );

   modport sink (
      input  valid, command, center_x, center_y, semi_axis_x, semi_axis_y,
      output ready
   );

endinterface

[rtl/mer_rsp_if.sv]
// Response channel of the midpoint ellipse rasterizer: valid/ready plus point quad word.
// Depends on mer_pkg.
interface mer_rsp_if;
   import mer_pkg::*;

   logic    valid;
   logic    ready;
   pix_type x_plus;
   pix_type x_minus;
   pix_type y_plus;
   pix_type y_minus;
   logic    last_quad;

   modport source (
      output valid, x_plus, x_minus, y_plus, y_minus, last_quad,
      input  ready
   );

   modport sink (
      input  valid, x_plus, x_minus, y_plus, y_minus, last_quad,
      output ready
   );

endinterface

[rtl/mer_mul.sv]
// Shared signed multiplier of the rasterizer, product registered.
// Depends on mer_pkg.
module mer_mul (
   input  logic                                clock,
   input  logic signed [mer_pkg::MUL_W-1:0]    op_a,
   input  logic signed [mer_pkg::MUL_W-1:0]    op_b,
   output logic signed [mer_pkg::PROD_W-1:0]   product
);
   import mer_pkg::*;

   mul_prod_type product_ff;

   // register the product for the sequencer to pick up next cycle
   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   assign product = product_ff;

endmodule

[rtl/midpoint_ellipse_rasterizer.sv]
// Midpoint ellipse rasterizer: a start word runs three multiplies on mer_mul.
// A step word passes the emit and decision states; its quad word is loaded into an output reg once it is free.
// Entering region two (at a step, or at start with a zero axis) adds a run of multiplies.
// Step word while idle: no quad. One word in flight.
// Synchronous reset clears sequencer, drawing flag and output valid; no clearing pass.
`include "midpoint_ellipse_rasterizer_assert.svh"
module midpoint_ellipse_rasterizer (
   input logic     clock,
   input logic     reset,
   mer_req_if.sink req_chan,
   mer_rsp_if.source rsp_chan
);
   import mer_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A2,
      ST_B2,
      ST_AB,
      ST_INIT,
      ST_EMIT,
      ST_DEC,
      ST_TX,
      ST_TY,
      ST_BTX,
      ST_ATY,
      ST_AB2,
      ST_FIN
   } state_type;

   // control registers
   state_type state_ff, state_in;
   logic      drawing_ff, drawing_in;
   logic      in_region_two_ff, in_region_two_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [OFFX_W-1:0]         offset_x_ff, offset_x_in;
   logic signed [OFFY_W-1:0]  offset_y_ff, offset_y_in;
   logic signed [DEC_W-1:0]   decision_ff, decision_in;
   logic signed [SLOPE_W-1:0] slope_x_ff, slope_x_in;
   logic signed [SLOPE_W-1:0] slope_y_ff, slope_y_in;
   coord_type                 centre_x_ff, centre_x_in;
   coord_type                 centre_y_ff, centre_y_in;
   coord_type                 a_hold_ff, a_hold_in;
   logic [SQ_W-1:0]           a_sq_ff, a_sq_in;
   logic [SQ_W-1:0]           b_sq_ff, b_sq_in;
   mul_op_type                tmp_a_ff, tmp_a_in;
   mul_op_type                tmp_b_ff, tmp_b_in;
   logic                      mv_x_ff, mv_x_in;
   logic                      mv_y_ff, mv_y_in;
   pix_type                   x_plus_ff, x_plus_in;
   pix_type                   x_minus_ff, x_minus_in;
   pix_type                   y_plus_ff, y_plus_in;
   pix_type                   y_minus_ff, y_minus_in;
   logic                      last_ff, last_in;

   // shared multiplier
   mul_op_type   mul_a;
   mul_op_type   mul_b;
   mul_prod_type prod;

   // helpers
   logic                      req_fire;
   logic                      out_free;
   logic                      step_mv_x;
   logic                      step_mv_y;
   logic signed [OFFY_W-1:0]  new_y;
   logic signed [OFFY_W-1:0]  ty;
   logic signed [DEC_W-1:0]   sx_ext;
   logic signed [DEC_W-1:0]   sy_ext;
   logic signed [DEC_W-1:0]   sq_ext;
   logic signed [DEC_W-1:0]   dec_term;
   logic signed [DEC_W-1:0]   prod_x4;

   mer_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // pick the move of this step from the decision sign
   assign step_mv_x = !in_region_two_ff || (decision_ff <= 0);
   assign step_mv_y = in_region_two_ff || (decision_ff >= 0);
   assign new_y     = step_mv_y ? (offset_y_ff - OFFY_W'(1)) : offset_y_ff;
   assign ty        = offset_y_ff - OFFY_W'(1);

   // decision increment terms, unscaled
   assign sx_ext   = mv_x_ff ? DEC_W'(slope_x_ff) : DEC_W'(0);
   assign sy_ext   = mv_y_ff ? DEC_W'(slope_y_ff) : DEC_W'(0);
   assign sq_ext   = $signed(DEC_W'(in_region_two_ff ? a_sq_ff : b_sq_ff));
   assign dec_term = sx_ext - sy_ext + sq_ext;
   assign prod_x4  = $signed({prod[DEC_W-3:0], 2'b00});

   // steer the multiplier operands per sequencer step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_A2: begin
            mul_a = $signed(MUL_W'(a_hold_ff));
            mul_b = $signed(MUL_W'(a_hold_ff));
         end
         ST_B2: begin
            mul_a = MUL_W'(offset_y_ff);
            mul_b = MUL_W'(offset_y_ff);
         end
         ST_AB: begin
            mul_a = $signed(MUL_W'(a_sq_ff));
            mul_b = MUL_W'(offset_y_ff);
         end
         ST_TX: begin
            mul_a = $signed(MUL_W'({offset_x_ff, 1'b1}));
            mul_b = $signed(MUL_W'({offset_x_ff, 1'b1}));
         end
         ST_TY: begin
            mul_a = MUL_W'(ty);
            mul_b = MUL_W'(ty);
         end
         ST_BTX: begin
            mul_a = $signed(MUL_W'(b_sq_ff));
            mul_b = tmp_a_ff;
         end
         ST_ATY: begin
            mul_a = $signed(MUL_W'(a_sq_ff));
            mul_b = tmp_b_ff;
         end
         ST_AB2: begin
            mul_a = $signed(MUL_W'(a_sq_ff));
            mul_b = $signed(MUL_W'(b_sq_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer: next state, control and datapath values
   always_comb begin
      state_in         = state_ff;
      drawing_in       = drawing_ff;
      in_region_two_in = in_region_two_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      offset_x_in      = offset_x_ff;
      offset_y_in      = offset_y_ff;
      decision_in      = decision_ff;
      slope_x_in       = slope_x_ff;
      slope_y_in       = slope_y_ff;
      centre_x_in      = centre_x_ff;
      centre_y_in      = centre_y_ff;
      a_hold_in        = a_hold_ff;
      a_sq_in          = a_sq_ff;
      b_sq_in          = b_sq_ff;
      tmp_a_in         = tmp_a_ff;
      tmp_b_in         = tmp_b_ff;
      mv_x_in          = mv_x_ff;
      mv_y_in          = mv_y_ff;
      x_plus_in        = x_plus_ff;
      x_minus_in       = x_minus_ff;
      y_plus_in        = y_plus_ff;
      y_minus_in       = y_minus_ff;
      last_in          = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.command == CMD_START) begin
                  // latch centre and axes, place the point at (0, b)
                  centre_x_in      = req_chan.center_x;
                  centre_y_in      = req_chan.center_y;
                  a_hold_in        = req_chan.semi_axis_x;
                  offset_x_in      = '0;
                  offset_y_in      = $signed(OFFY_W'(req_chan.semi_axis_y));
                  slope_x_in       = '0;
                  in_region_two_in = 1'b0;
                  drawing_in       = 1'b1;
                  state_in         = ST_A2;
               end else if (drawing_ff) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_A2: begin
            state_in = ST_B2;
         end
         ST_B2: begin
            a_sq_in  = prod[SQ_W-1:0];
            state_in = ST_AB;
         end
         ST_AB: begin
            b_sq_in  = prod[SQ_W-1:0];
            state_in = ST_INIT;
         end
         ST_INIT: begin
            // product holds a^2 b
            slope_y_in  = $signed({prod[SLOPE_W-2:0], 1'b0});
            decision_in = $signed(DEC_W'({b_sq_ff, 2'b00}) - {prod[DEC_W-3:0], 2'b00}
                                  + DEC_W'(a_sq_ff));
            state_in    = (prod == '0) ? ST_TX : ST_IDLE;
         end
         ST_EMIT: begin
            // hold until the output register is free, then load the quad and move
            if (out_free) begin
               rsp_valid_in = 1'b1;
               x_plus_in    = $signed(OUT_BITS'(centre_x_ff) + OUT_BITS'(offset_x_ff));
               x_minus_in   = $signed(OUT_BITS'(centre_x_ff) - OUT_BITS'(offset_x_ff));
               y_plus_in    = $signed(OUT_BITS'(centre_y_ff) + OUT_BITS'(offset_y_ff));
               y_minus_in   = $signed(OUT_BITS'(centre_y_ff) - OUT_BITS'(offset_y_ff));
               last_in      = new_y[OFFY_W-1];
               drawing_in   = !new_y[OFFY_W-1];
               mv_x_in      = step_mv_x;
               mv_y_in      = step_mv_y;
               offset_y_in  = new_y;
               if (step_mv_x) begin
                  offset_x_in = offset_x_ff + OFFX_W'(1);
                  slope_x_in  = slope_x_ff + $signed(SLOPE_W'({b_sq_ff, 1'b0}));
               end
               if (step_mv_y) begin
                  slope_y_in = slope_y_ff - $signed(SLOPE_W'({a_sq_ff, 1'b0}));
               end
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            // advance the decision value, switch region when the slope test fails
            decision_in = decision_ff + $signed({dec_term[DEC_W-3:0], 2'b00});
            if (!in_region_two_ff && !(slope_x_ff < slope_y_ff)) begin
               state_in = ST_TX;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TX: begin
            state_in = ST_TY;
         end
         ST_TY: begin
            tmp_a_in = prod[MUL_W-1:0];
            state_in = ST_BTX;
         end
         ST_BTX: begin
            tmp_b_in = prod[MUL_W-1:0];
            state_in = ST_ATY;
         end
         ST_ATY: begin
            decision_in = prod[DEC_W-1:0];
            state_in    = ST_AB2;
         end
         ST_AB2: begin
            decision_in = decision_ff + prod_x4;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            decision_in      = decision_ff - prod_x4;
            in_region_two_in = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state, drawing and region flags and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         drawing_ff       <= 1'b0;
         in_region_two_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         drawing_ff       <= drawing_in;
         in_region_two_ff <= in_region_two_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // advance datapath and output word registers
   always_ff @(posedge clock) begin
      offset_x_ff <= offset_x_in;
      offset_y_ff <= offset_y_in;
      decision_ff <= decision_in;
      slope_x_ff  <= slope_x_in;
      slope_y_ff  <= slope_y_in;
      centre_x_ff <= centre_x_in;
      centre_y_ff <= centre_y_in;
      a_hold_ff   <= a_hold_in;
      a_sq_ff     <= a_sq_in;
      b_sq_ff     <= b_sq_in;
      tmp_a_ff    <= tmp_a_in;
      tmp_b_ff    <= tmp_b_in;
      mv_x_ff     <= mv_x_in;
      mv_y_ff     <= mv_y_in;
      x_plus_ff   <= x_plus_in;
      x_minus_ff  <= x_minus_in;
      y_plus_ff   <= y_plus_in;
      y_minus_ff  <= y_minus_in;
      last_ff     <= last_in;
   end

   // drive the channels
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.x_plus    = x_plus_ff;
   assign rsp_chan.x_minus   = x_minus_ff;
   assign rsp_chan.y_plus    = y_plus_ff;
   assign rsp_chan.y_minus   = y_minus_ff;
   assign rsp_chan.last_quad = last_ff;

   // a loaded quad word is presented next cycle
   `MER_ASSERT_NEXT(a_emit_valid, (state_ff == ST_EMIT) && out_free, rsp_valid_ff)
   // the final quad ends drawing
   `MER_ASSERT_NEXT(a_last_stops, (state_ff == ST_EMIT) && out_free && new_y[OFFY_W-1], !drawing_ff && last_ff)
   // region one always moves in x, region two always in y
   `MER_ASSERT_NOW(a_r1_moves_x, (state_ff == ST_DEC) && !in_region_two_ff, mv_x_ff)
   `MER_ASSERT_NOW(a_r2_moves_y, (state_ff == ST_DEC) && in_region_two_ff, mv_y_ff)
   // a start word enters the squaring sequence
   `MER_ASSERT_NEXT(a_start_seq, req_fire && (req_chan.command == CMD_START), state_ff == ST_A2)

endmodule

[tb/ellipse_quad_checker.sv]
// Watches the request and response channels of the midpoint ellipse rasterizer,
// predicts every point quad word and compares it with what the block returns.
// Depends on mer_pkg and the mer_req_if / mer_rsp_if interfaces.
module ellipse_quad_checker (
   input  logic clock,
   input  logic reset,
   mer_req_if   req,
   mer_rsp_if   rsp,
   output int   fail_count,
   output int   pending,
   output int   quads_seen,
   output int   arcs_closed
);
   import mer_pkg::*;

   typedef struct packed {
      pix_type x_plus;
      pix_type x_minus;
      pix_type y_plus;
      pix_type y_minus;
      logic    last_quad;
   } quad_word;

   // tracer state at the block's widths
   logic [OFFX_W-1:0]         off_x;
   logic signed [OFFY_W-1:0]  off_y;
   logic signed [DEC_W-1:0]   dvar;
   logic signed [SLOPE_W-1:0] grad_x;
   logic signed [SLOPE_W-1:0] grad_y;
   logic                      in_outer;
   logic                      tracing;
   coord_type                 ctr_x;
   coord_type                 ctr_y;
   logic [SQ_W-1:0]           asq;
   logic [SQ_W-1:0]           bsq;

   quad_word quads_due[$];

   // clear the tracer
   function automatic void clear_tracer();
      off_x    = '0;
      off_y    = '0;
      dvar     = '0;
      grad_x   = '0;
      grad_y   = '0;
      in_outer = 1'b0;
      tracing  = 1'b0;
      ctr_x    = '0;
      ctr_y    = '0;
      asq      = '0;
      bsq      = '0;
   endfunction

   // set up the steep part of the arc from the current point
   function automatic void enter_outer_arc();
      longint tx, ty, aq, bq;
      tx = 2 * longint'(off_x) + 1;
      ty = longint'(off_y) - 1;
      aq = longint'(asq);
      bq = longint'(bsq);
      in_outer = 1'b1;
      dvar = DEC_W'(bq * tx * tx + 4 * aq * ty * ty - 4 * aq * bq);
   endfunction

   // advance the tracer by one request word; return 1 when it yields a quad
   function automatic logic trace_word(input command_type cmd, input coord_type cx,
                                       input coord_type cy, input coord_type a,
                                       input coord_type b, output quad_word q);
      longint aq, bq, sum;
      q = '0;
      if (cmd == CMD_START) begin
         asq    = SQ_W'(longint'(a) * longint'(a));
         bsq    = SQ_W'(longint'(b) * longint'(b));
         aq     = longint'(asq);
         bq     = longint'(bsq);
         ctr_x  = cx;
         ctr_y  = cy;
         off_x  = '0;
         off_y  = OFFY_W'(b);
         grad_x = '0;
         grad_y = SLOPE_W'(2 * aq * longint'(b));
         dvar   = DEC_W'(4 * bq - 4 * aq * longint'(b) + aq);
         in_outer = 1'b0;
         // degenerate axes skip the flat part entirely
         if (!(longint'(grad_x) < longint'(grad_y)))
            enter_outer_arc();
         tracing = 1'b1;
         return 1'b0;
      end
      if (!tracing)
         return 1'b0;

      // mirror the current offset around the centre, wrapped to the output width
      sum = longint'(ctr_x) + longint'(off_x);
      q.x_plus = sum[OUT_BITS-1:0];
      sum = longint'(ctr_x) - longint'(off_x);
      q.x_minus = sum[OUT_BITS-1:0];
      sum = longint'(ctr_y) + longint'(off_y);
      q.y_plus = sum[OUT_BITS-1:0];
      sum = longint'(ctr_y) - longint'(off_y);
      q.y_minus = sum[OUT_BITS-1:0];

      aq = longint'(asq);
      bq = longint'(bsq);
      if (!in_outer) begin
         off_x  = off_x + OFFX_W'(1);
         grad_x = SLOPE_W'(longint'(grad_x) + 2 * bq);
         if (dvar < 0) begin
            dvar = DEC_W'(longint'(dvar) + 4 * (longint'(grad_x) + bq));
         end else begin
            off_y  = off_y - OFFY_W'(1);
            grad_y = SLOPE_W'(longint'(grad_y) - 2 * aq);
            dvar   = DEC_W'(longint'(dvar) + 4 * (longint'(grad_x) - longint'(grad_y) + bq));
         end
         if (!(longint'(grad_x) < longint'(grad_y)))
            enter_outer_arc();
      end else begin
         off_y  = off_y - OFFY_W'(1);
         grad_y = SLOPE_W'(longint'(grad_y) - 2 * aq);
         if (dvar > 0) begin
            dvar = DEC_W'(longint'(dvar) + 4 * (aq - longint'(grad_y)));
         end else begin
            off_x  = off_x + OFFX_W'(1);
            grad_x = SLOPE_W'(longint'(grad_x) + 2 * bq);
            dvar   = DEC_W'(longint'(dvar) + 4 * (longint'(grad_x) - longint'(grad_y) + aq));
         end
      end

      // the arc is done once y has passed below the axis
      q.last_quad = (off_y < 0);
      tracing = !q.last_quad;
      return 1'b1;
   endfunction

   // check returned words first, then predict the accepted request word
   always @(posedge clock) begin : watch
      quad_word got, want, next_q;
      if (reset) begin
         clear_tracer();
         quads_due.delete();
         fail_count  = 0;
         quads_seen  = 0;
         arcs_closed = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.x_plus, rsp.x_minus, rsp.y_plus, rsp.y_minus, rsp.last_quad};
            quads_seen++;
            if (got.last_quad === 1'b1)
               arcs_closed++;
            if (quads_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected quad word: xp=%0d xm=%0d yp=%0d ym=%0d last=%0b",
                           got.x_plus, got.x_minus, got.y_plus, got.y_minus,
                           got.last_quad);
            end else begin
               want = quads_due.pop_front();
               if (got.x_plus !== want.x_plus || got.x_minus !== want.x_minus ||
                   got.y_plus !== want.y_plus || got.y_minus !== want.y_minus ||
                   got.last_quad !== want.last_quad) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("quad mismatch: expected xp=%0d xm=%0d yp=%0d ym=%0d last=%0b",
                              want.x_plus, want.x_minus, want.y_plus, want.y_minus,
                              want.last_quad);
                     $display("               actual   xp=%0d xm=%0d yp=%0d ym=%0d last=%0b",
                              got.x_plus, got.x_minus, got.y_plus, got.y_minus,
                              got.last_quad);
                  end
               end
            end
         end
         if (req.valid && req.ready) begin
            if (trace_word(req.command, req.center_x, req.center_y,
                           req.semi_axis_x, req.semi_axis_y, next_q))
               quads_due.push_back(next_q);
         end
      end
      pending <= quads_due.size();
   end

endmodule

[tb/midpoint_ellipse_rasterizer_tb.sv]
// Stimulus and verdict for the midpoint ellipse rasterizer: directed ellipses,
// then random ones with idle bursts on both channels. Uses ellipse_quad_checker.
// Depends on mer_pkg, mer_req_if, mer_rsp_if and the rasterizer itself.
module midpoint_ellipse_rasterizer_tb;
   import mer_pkg::*;

   localparam int RANDOM_WORDS = 1000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_LIMIT  = 4000;

   logic clock = 1'b0;
   logic reset;

   mer_req_if req_chan ();
   mer_rsp_if rsp_chan ();

   int  fail_count, pending, quads_seen, arcs_closed;
   int  words_sent, starts_sent, steps_sent;
   bit  calm;
   bit  hold_now;

   midpoint_ellipse_rasterizer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ellipse_quad_checker watch (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .fail_count  (fail_count),
      .pending     (pending),
      .quads_seen  (quads_seen),
      .arcs_closed (arcs_closed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // give up if the run hangs
   initial begin
      #2000000;
      $display("timeout: run did not complete");
      $display("status: fail");
      $finish;
   end

   // offer one request word, maybe after an idle burst, and hold it until taken
   task automatic send_word(input command_type cmd, input coord_type cx, input coord_type cy,
                            input coord_type a, input coord_type b);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= cmd;
      req_chan.center_x    <= cx;
      req_chan.center_y    <= cy;
      req_chan.semi_axis_x <= a;
      req_chan.semi_axis_y <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
      if (cmd == CMD_START)
         starts_sent++;
      else
         steps_sent++;
   endtask

   // start an ellipse, then issue a number of step words with junk payload
   task automatic draw_ellipse(input coord_type cx, input coord_type cy,
                               input coord_type a, input coord_type b, input int n_steps);
      send_word(CMD_START, cx, cy, a, b);
      repeat (n_steps)
         send_word(CMD_STEP, coord_type'($urandom), coord_type'($urandom),
                   coord_type'($urandom), coord_type'($urandom));
   endtask

   // stop offering and wait until every predicted quad has come back
   task automatic settle_quads();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // response side: random ready bursts, one long hold on request
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_now) begin
            hold_now = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // request side and verdict
   initial begin
      int        directed_words;
      int        pick, sz, n;
      bit        hold_armed, pause_done;
      coord_type a, b;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.command     <= CMD_START;
      req_chan.center_x    <= '0;
      req_chan.center_y    <= '0;
      req_chan.semi_axis_x <= '0;
      req_chan.semi_axis_y <= '0;
      calm       = 1'b0;
      hold_now   = 1'b0;
      hold_armed = 1'b0;
      pause_done = 1'b0;
      words_sent = 0;
      starts_sent = 0;
      steps_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: step while idle, zero axes, vertical line, extremes, restart mid-arc
      send_word(CMD_STEP, '1, '1, '1, '1);
      draw_ellipse('0, '0, '0, '0, 2);
      draw_ellipse(10'd1023, '0, '0, 10'd3, 5);
      draw_ellipse(10'd1023, 10'd1023, 10'd1023, 10'd1023, 3);
      draw_ellipse('0, 10'd1023, 10'd3, 10'd2, 8);
      settle_quads();
      directed_words = words_sent;

      // random: mostly whole ellipses with small axes, some cut short, some stray steps
      while (words_sent < directed_words + RANDOM_WORDS) begin
         if (words_sent >= directed_words + RANDOM_WORDS - 100)
            calm = 1'b1;
         if (!hold_armed && words_sent >= directed_words + 300) begin
            hold_armed = 1'b1;
            hold_now   = 1'b1;
         end
         if (!pause_done && words_sent >= directed_words + 600) begin
            pause_done = 1'b1;
            settle_quads();
         end
         pick = $urandom_range(0, 99);
         sz   = $urandom_range(0, 99);
         if (sz < 80) begin
            a = coord_type'($urandom_range(0, 12));
            b = coord_type'($urandom_range(0, 12));
         end else if (sz < 95) begin
            a = coord_type'($urandom_range(0, 60));
            b = coord_type'($urandom_range(0, 60));
         end else begin
            a = coord_type'($urandom);
            b = coord_type'($urandom);
         end
         if (pick < 75 && sz < 95) begin
            n = int'(a) + int'(b) + 3 + $urandom_range(0, 2);
            draw_ellipse(coord_type'($urandom), coord_type'($urandom), a, b, n);
         end else if (pick < 92) begin
            n = $urandom_range(0, (sz < 95) ? int'(a) + int'(b) + 1 : 40);
            draw_ellipse(coord_type'($urandom), coord_type'($urandom), a, b, n);
         end else begin
            repeat ($urandom_range(1, 3))
               send_word(CMD_STEP, coord_type'($urandom), coord_type'($urandom),
                         coord_type'($urandom), coord_type'($urandom));
         end
      end

      // drain, then leave time for any stray word to show up
      req_chan.valid <= 1'b0;
      for (int k = 0; k < DRAIN_LIMIT && pending != 0; k++) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d words (%0d starts, %0d steps) and %0d returned quads",
               words_sent, starts_sent, steps_sent, quads_seen);
      $display("%0d ellipses traced to their last quad, %0d mismatches, %0d quads missing",
               arcs_closed, fail_count, pending);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/mer_pkg.sv
rtl/mer_req_if.sv
rtl/mer_rsp_if.sv
rtl/mer_mul.sv
rtl/midpoint_ellipse_rasterizer.sv
tb/ellipse_quad_checker.sv
tb/midpoint_ellipse_rasterizer_tb.sv
